>>> rtl/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types, codes and constants of the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

    // Widths of the stream fields
    localparam int CMD_BITS  = 2;
    localparam int RAW_BITS  = 10;
    localparam int GEST_BITS = 3;
    localparam int SX_BITS   = 10;
    localparam int SY_BITS   = 9;
    localparam int CFG_BITS  = 16;
    localparam int CIDX_BITS = 2;

    // Touch and gap counters
    localparam int TIME_BITS = 16;
    localparam int CMP_BITS  = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

    // Stream bit widths
    localparam int S_TDATA_BITS = 16;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 24;

    // Coordinate scaling: x = raw*25/32, y = floor(raw*4/5) via reciprocal
    localparam int XMUL_BITS = 15;
    localparam logic [XMUL_BITS-RAW_BITS-1:0] X_MUL = 5'd25;
    localparam int X_SHIFT   = 5;
    localparam int YMUL_BITS = 24;
    localparam logic [YMUL_BITS-RAW_BITS-1:0] Y_MUL = 14'd13108;
    localparam int Y_SHIFT   = 14;
    localparam logic [SY_BITS-1:0] Y_MAX = 9'd479;

    // Commands
    localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_X       = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_Y       = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd3;

    // Gestures
    localparam logic [GEST_BITS-1:0] G_UP     = 3'd0;
    localparam logic [GEST_BITS-1:0] G_DOWN   = 3'd1;
    localparam logic [GEST_BITS-1:0] G_LEFT   = 3'd2;
    localparam logic [GEST_BITS-1:0] G_RIGHT  = 3'd3;
    localparam logic [GEST_BITS-1:0] G_CLICK  = 3'd4;
    localparam logic [GEST_BITS-1:0] G_DCLICK = 3'd5;
    localparam logic [GEST_BITS-1:0] G_LONG   = 3'd6;
    localparam logic [GEST_BITS-1:0] G_NONE   = 3'd7;

    // Phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_TOUCH   = 2'd1;
    localparam logic [1:0] PH_TAPWAIT = 2'd2;
    localparam logic [1:0] PH_SECOND  = 2'd3;

    // Seen-point marks
    localparam logic [3:0] M_FX = 4'b0001;
    localparam logic [3:0] M_FY = 4'b0010;
    localparam logic [3:0] M_LX = 4'b0100;
    localparam logic [3:0] M_LY = 4'b1000;

    // Configuration register indexes
    localparam logic [CIDX_BITS-1:0] REG_TAP_MAX    = 2'd0;
    localparam logic [CIDX_BITS-1:0] REG_LONG_MIN   = 2'd1;
    localparam logic [CIDX_BITS-1:0] REG_DTAP_WIN   = 2'd2;

    localparam logic [CFG_BITS-1:0] TAP_MAX_RST  = 16'd300;
    localparam logic [CFG_BITS-1:0] LONG_MIN_RST = 16'd500;
    localparam logic [CFG_BITS-1:0] DTAP_WIN_RST = 16'd500;

    // Event after scaling
    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic                raw_nz;
        logic [SX_BITS-1:0]  x;
        logic [SY_BITS-1:0]  y;
    } item_t;

    // Classified gesture
    typedef struct packed {
        logic [GEST_BITS-1:0] gesture;
        logic [SX_BITS-1:0]   screen_x;
        logic [SY_BITS-1:0]   screen_y;
    } result_t;

endpackage

>>> rtl/tgc_scale.sv
// ----------------------------------------------------------------------------
// tgc_scale
// Input register: captures an event and scales its coordinate to screen pixels.
// ----------------------------------------------------------------------------
module tgc_scale
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tgc_pkg::CMD_BITS-1:0]   cmd,
    input  logic [tgc_pkg::RAW_BITS-1:0]   raw,
    output logic                           item_valid,
    input  logic                           item_take,
    output tgc_pkg::item_t                 item
);
    import tgc_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    item_t                 item_reg;
    item_t                 item_next;
    logic [XMUL_BITS-1:0]  x_prod;
    logic [YMUL_BITS-1:0]  y_prod;
    logic [RAW_BITS-1:0]   y_full;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    assign x_prod = XMUL_BITS'(raw) * XMUL_BITS'(X_MUL);
    assign y_prod = YMUL_BITS'(raw) * YMUL_BITS'(Y_MUL);
    assign y_full = y_prod[Y_SHIFT +: RAW_BITS];

    always_comb
    begin
        item_next.cmd    = cmd;
        item_next.raw_nz = (raw != '0);
        item_next.x      = x_prod[X_SHIFT +: SX_BITS];
        // saturate the bottom edge of the panel
        item_next.y      = (y_full > RAW_BITS'(Y_MAX)) ? Y_MAX : y_full[SY_BITS-1:0];
        valid_next       = in_valid ? 1'b1 : (item_take ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> rtl/tgc_core.sv
// ----------------------------------------------------------------------------
// tgc_core
// Gesture state machine: tracks touch points and timers, classifies on release.
// ----------------------------------------------------------------------------
module tgc_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tgc_pkg::CIDX_BITS-1:0]   cfg_index,
    input  logic [tgc_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                            fire,
    input  tgc_pkg::item_t                  item,
    output logic                            push,
    output tgc_pkg::result_t                res
);
    import tgc_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [CFG_BITS-1:0]  tap_max_reg;
    logic [CFG_BITS-1:0]  long_min_reg;
    logic [CFG_BITS-1:0]  dtap_win_reg;

    logic [1:0]           phase_reg,    phase_next;
    logic [SX_BITS-1:0]   first_x_reg,  first_x_next;
    logic [SY_BITS-1:0]   first_y_reg,  first_y_next;
    logic [SX_BITS-1:0]   latest_x_reg, latest_x_next;
    logic [SY_BITS-1:0]   latest_y_reg, latest_y_next;
    logic [3:0]           marks_reg,    marks_next;
    logic [TIME_BITS-1:0] touch_reg,    touch_next;
    logic [TIME_BITS-1:0] gap_reg,      gap_next;
    logic [SX_BITS-1:0]   tap_x_reg,    tap_x_next;
    logic [SY_BITS-1:0]   tap_y_reg,    tap_y_next;

    logic [TIME_BITS-1:0] touch_inc;
    logic [TIME_BITS-1:0] gap_inc;
    logic                 new_touch;
    logic [3:0]           marks_base;
    logic signed [SX_BITS:0] dx;
    logic signed [SX_BITS:0] dy;
    logic [SX_BITS:0]     ax;
    logic [SX_BITS:0]     ay;
    logic [GEST_BITS-1:0] swipe;
    logic                 is_tap;
    logic                 is_long;
    logic                 win_done;

    assign touch_inc = (touch_reg == TIME_MAX) ? touch_reg : touch_reg + 1'b1;
    assign gap_inc   = (gap_reg == TIME_MAX) ? gap_reg : gap_reg + 1'b1;
    assign win_done  = CMP_BITS'(gap_inc) >= CMP_BITS'(dtap_win_reg);
    assign is_tap    = CMP_BITS'(touch_reg) <= CMP_BITS'(tap_max_reg);
    assign is_long   = CMP_BITS'(touch_reg) > CMP_BITS'(long_min_reg);

    // a sample in idle or during the tap window opens a fresh touch
    assign new_touch  = (phase_reg == PH_IDLE) || (phase_reg == PH_TAPWAIT);
    assign marks_base = new_touch ? 4'b0000 : marks_reg;

    assign dx = $signed({1'b0, latest_x_reg}) - $signed({1'b0, first_x_reg});
    assign dy = $signed({2'b00, latest_y_reg}) - $signed({2'b00, first_y_reg});
    assign ax = dx[SX_BITS] ? (SX_BITS+1)'(0) - dx : dx;
    assign ay = dy[SX_BITS] ? (SX_BITS+1)'(0) - dy : dy;

    always_comb
    begin
        if (ax <= ay)
        begin
            swipe = dy[SX_BITS] ? G_UP : G_DOWN;
        end
        else
        begin
            swipe = (!dx[SX_BITS] && (dx != '0)) ? G_RIGHT : G_LEFT;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        latest_x_next = latest_x_reg;
        latest_y_next = latest_y_reg;
        marks_next    = marks_reg;
        touch_next    = touch_reg;
        gap_next      = gap_reg;
        tap_x_next    = tap_x_reg;
        tap_y_next    = tap_y_reg;
        push          = 1'b0;
        res.gesture   = G_NONE;
        res.screen_x  = '0;
        res.screen_y  = '0;

        if (fire)
        begin
            case (item.cmd)
                CMD_TICK:
                begin
                    if ((phase_reg == PH_TOUCH) || (phase_reg == PH_SECOND))
                    begin
                        touch_next = touch_inc;
                    end
                    else if (phase_reg == PH_TAPWAIT)
                    begin
                        gap_next = gap_inc;
                        if (win_done)
                        begin
                            phase_next   = PH_IDLE;
                            push         = 1'b1;
                            res.gesture  = G_CLICK;
                            res.screen_x = tap_x_reg;
                            res.screen_y = tap_y_reg;
                        end
                    end
                end
                CMD_X, CMD_Y:
                begin
                    if (item.raw_nz)
                    begin
                        if (new_touch)
                        begin
                            phase_next = (phase_reg == PH_IDLE) ? PH_TOUCH : PH_SECOND;
                            touch_next = '0;
                        end
                        if (item.cmd == CMD_X)
                        begin
                            if ((marks_base & M_FX) != '0)
                            begin
                                latest_x_next = item.x;
                                marks_next    = marks_base | M_LX;
                            end
                            else
                            begin
                                first_x_next = item.x;
                                marks_next   = marks_base | M_FX;
                            end
                        end
                        else
                        begin
                            if ((marks_base & M_FY) != '0)
                            begin
                                latest_y_next = item.y;
                                marks_next    = marks_base | M_LY;
                            end
                            else
                            begin
                                first_y_next = item.y;
                                marks_next   = marks_base | M_FY;
                            end
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    case (phase_reg)
                        PH_TAPWAIT:
                        begin
                        end
                        PH_SECOND:
                        begin
                            phase_next   = PH_IDLE;
                            marks_next   = '0;
                            push         = 1'b1;
                            res.gesture  = G_DCLICK;
                            res.screen_x = tap_x_reg;
                            res.screen_y = tap_y_reg;
                        end
                        PH_TOUCH:
                        begin
                            phase_next = PH_IDLE;
                            marks_next = '0;
                            push       = 1'b1;
                            if (marks_reg == (M_FX | M_FY | M_LX | M_LY))
                            begin
                                res.gesture = swipe;
                            end
                            else if ((marks_reg == (M_FX | M_FY)) && is_tap)
                            begin
                                tap_x_next = first_x_reg;
                                tap_y_next = first_y_reg;
                                if (dtap_win_reg == '0)
                                begin
                                    res.gesture  = G_CLICK;
                                    res.screen_x = first_x_reg;
                                    res.screen_y = first_y_reg;
                                end
                                else
                                begin
                                    // hold the tap until the window closes or a touch follows
                                    push       = 1'b0;
                                    phase_next = PH_TAPWAIT;
                                    gap_next   = '0;
                                end
                            end
                            else if ((marks_reg == (M_FX | M_FY)) && is_long)
                            begin
                                res.gesture  = G_LONG;
                                res.screen_x = first_x_reg;
                                res.screen_y = first_y_reg;
                            end
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_max_reg  <= TAP_MAX_RST;
            long_min_reg <= LONG_MIN_RST;
            dtap_win_reg <= DTAP_WIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAP_MAX:  tap_max_reg  <= cfg_data;
                REG_LONG_MIN: long_min_reg <= cfg_data;
                REG_DTAP_WIN: dtap_win_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            latest_x_reg <= '0;
            latest_y_reg <= '0;
            marks_reg    <= '0;
            touch_reg    <= '0;
            gap_reg      <= '0;
            tap_x_reg    <= '0;
            tap_y_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            first_x_reg  <= first_x_next;
            first_y_reg  <= first_y_next;
            latest_x_reg <= latest_x_next;
            latest_y_reg <= latest_y_next;
            marks_reg    <= marks_next;
            touch_reg    <= touch_next;
            gap_reg      <= gap_next;
            tap_x_reg    <= tap_x_next;
            tap_y_reg    <= tap_y_next;
        end
    end

    a_tapwait_no_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TAPWAIT) |-> (marks_reg == '0))
        else $error("marks left set while waiting for a second tap");

    a_latest_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        ((!marks_reg[2] || marks_reg[0]) && (!marks_reg[3] || marks_reg[1])))
        else $error("latest point recorded before first point");

    a_dclick_from_second: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (res.gesture == G_DCLICK)) |-> (phase_reg == PH_SECOND))
        else $error("double click outside a second touch");

    a_click_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (res.gesture == G_CLICK)) |=> (phase_reg == PH_IDLE))
        else $error("click issued without returning to idle");

endmodule

>>> rtl/tgc_out_buf.sv
// ----------------------------------------------------------------------------
// tgc_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module tgc_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tgc_pkg::result_t   push_data,
    output logic               can_push,
    output logic               out_valid,
    input  logic               out_ready,
    output tgc_pkg::result_t   out_data
);
    import tgc_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pop       = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (!out_valid_reg)
            begin
                out_valid_reg <= push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (push && (pop || !out_valid_reg))
        begin
            out_reg <= push_data;
        end
        if (push && out_valid_reg && !pop)
        begin
            skid_reg <= push_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !pop) |=> skid_valid_reg)
        else $error("skid entry lost without a transfer");

endmodule

>>> rtl/touch_gesture_classifier_top.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_top
// Touch gesture classifier: swipes, click, double click and long press.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries touch events: s_tuser is the command (tick, X sample,
//   Y sample, release) and s_tdata the raw 10-bit coordinate.
//   m_* carries one gesture per classifying event: gesture, screen X and
//   screen Y packed in m_tdata. Most events produce no transfer on m_*.
//   cfg_* writes the tap, long press and double tap limits; write them
//   only while no event is in flight. cfg_ready is always high.
// Timing:
//   One event per cycle while s_tready is high. An accepted event lands
//   in the input register (coordinate scaled there); the state machine
//   classifies it combinationally as it leaves that register; its result
//   goes to the output register (or the skid register while it is full).
// Reset:
//   rst_n clears the gesture state to idle and reloads the limits
//   300 / 500 / 500 ms. No results are pending after reset.
// Back-pressure:
//   A stalled m_tready fills the output and skid registers; s_tready
//   drops only once the skid register is occupied.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [tgc_pkg::S_TDATA_BITS-1:0]      s_tdata,   // [9:0] raw_value
    input  logic [tgc_pkg::S_TUSER_BITS-1:0]      s_tuser,   // [1:0] command
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tgc_pkg::M_TDATA_BITS-1:0]      m_tdata,   // [2:0] gesture,
                                                             // [12:3] screen_x,
                                                             // [21:13] screen_y
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tgc_pkg::CIDX_BITS-1:0]         cfg_index,
    input  logic [tgc_pkg::CFG_BITS-1:0]          cfg_data
);
    import tgc_pkg::*;

    logic    item_valid;
    logic    item_take;
    item_t   item;
    logic    push;
    result_t res;
    logic    can_push;
    result_t out_data;

    assign cfg_ready = 1'b1;
    assign item_take = item_valid && can_push;

    tgc_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tuser[CMD_BITS-1:0]),
        .raw        (s_tdata[RAW_BITS-1:0]),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    tgc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (item_take),
        .item      (item),
        .push      (push),
        .res       (res)
    );

    tgc_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {2'b00, out_data.screen_y, out_data.screen_x, out_data.gesture};

endmodule
